>>> sv/wshr_pkg.sv
`default_nettype none

package wshr_pkg;

  localparam int MAX_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int FIELD_COORD_W   = 12;
  localparam int WIN_ID_W        = 5;
  localparam int CNT_W           = 5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CLICK = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [WIN_ID_W-1:0]      window_index;
    logic [FIELD_COORD_W-1:0] left_edge;
    logic [FIELD_COORD_W-1:0] bottom_edge;
    logic [FIELD_COORD_W-1:0] right_edge;
    logic [FIELD_COORD_W-1:0] top_edge;
    logic [FIELD_COORD_W-1:0] point_x;
    logic [FIELD_COORD_W-1:0] point_y;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [WIN_ID_W-1:0] window_id;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

>>> sv/wshr_ram.sv
`default_nettype none

module wshr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/window_stack_hit_raise_core.sv
// Window stack with hit test and raise-to-front.
// Input channel: an item is taken at a clock edge with start high and busy low.
// A load item writes one window rectangle at its stack position in the same
// cycle, if window_index is 1 to MAX_WINDOWS, and gives no result. A click
// item scans the stack top down, one entry per cycle through the stack
// memory's read port, then rotates the entries above a hit down one place,
// one entry per cycle, and writes the hit window to the top.
// A click keeps busy high while it scans and, on a hit, while it rotates;
// busy does not rise for a click on an empty stack. The result strobes in
// the first cycle in which busy is low again, or in the cycle after the
// beat on an empty stack. The stack memory has a registered read port and
// a single write port.
// Output: result_valid strobes for exactly one cycle with hit and window_id
// (zero on a miss); the receiver cannot stall it.
// Configuration: cfg_data sets window_count when cfg_valid is high; cfg_ready
// is always high. Write it only while busy is low.
// Reset: rst clears control and sets window_count to 1. The stack contents
// are undefined until loaded.
`default_nettype none

module window_stack_hit_raise_core
  import wshr_pkg::*;
#(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire req_t             req,
  output logic                  busy,
  output logic                  result_valid,
  output rsp_t                  result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int AW      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW      = $clog2(MAX_WINDOWS + 1);
  localparam int EW      = (CW > CNT_W) ? CW : CNT_W;
  localparam int CB      = COORD_BITS;
  localparam int ENTRY_W = 4 * CB + WIN_ID_W;

  state_t state, state_next;

  logic [CNT_W-1:0]   window_count;
  logic [EW-1:0]      cnt_ext;
  logic [CW-1:0]      n_act;
  logic               load_ok;

  logic [CB-1:0]      px, py;
  logic [CW-1:0]      n_r;
  logic [AW-1:0]      ptr;
  logic               issue;
  logic               chk_vld;
  logic [AW-1:0]      chk_pos;
  logic [ENTRY_W-1:0] picked;
  logic [CW-1:0]      sp;
  logic               sh_vld;
  logic [CW-1:0]      sh_pos;
  logic               sp_more;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] load_entry;
  logic               in_rect;

  logic [CB-1:0] e_xl, e_yl, e_xh, e_yh;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  assign cnt_ext = EW'(window_count);
  assign n_act   = CW'((cnt_ext > EW'(MAX_WINDOWS)) ? EW'(MAX_WINDOWS) : cnt_ext);
  assign load_ok = (req.window_index != '0) &&
                   (EW'(req.window_index) <= EW'(MAX_WINDOWS));

  assign load_entry = {req.window_index, CB'(req.top_edge), CB'(req.right_edge),
                       CB'(req.bottom_edge), CB'(req.left_edge)};

  assign e_xl = rd_data[CB-1:0];
  assign e_yl = rd_data[2*CB-1:CB];
  assign e_xh = rd_data[3*CB-1:2*CB];
  assign e_yh = rd_data[4*CB-1:3*CB];

  assign in_rect = (px >= e_xl) && (px <= e_xh) && (py >= e_yl) && (py <= e_yh);
  assign sp_more = (sp < n_r);

  assign ram_raddr = (state == ST_SHIFT) ? AW'(sp) : ptr;

  wshr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WINDOWS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = AW'(req.window_index - WIN_ID_W'(1));
    ram_wdata  = load_entry;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_LOAD) begin
            ram_we = load_ok;
          end else if (n_act != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chk_vld) begin
          if (in_rect) begin
            state_next = ST_SHIFT;
          end else if (chk_pos == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        if (sh_vld) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(sh_pos - CW'(1));
          ram_wdata = rd_data;
        end else if (!sp_more) begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(n_r - CW'(1));
          ram_wdata  = picked;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= CNT_W'(1);
      issue        <= 1'b0;
      chk_vld      <= 1'b0;
      sh_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          chk_vld      <= 1'b0;
          sh_vld       <= 1'b0;
          result_valid <= start && (req.req_type == REQ_CLICK) && (n_act == '0);
          if (start && req.req_type == REQ_CLICK) begin
            issue <= (n_act != '0);
          end
        end
        ST_SCAN: begin
          result_valid <= chk_vld && !in_rect && (chk_pos == '0);
          if (chk_vld && (in_rect || chk_pos == '0)) begin
            chk_vld <= 1'b0;
            issue   <= 1'b0;
            sh_vld  <= 1'b0;
          end else begin
            chk_vld <= issue;
            if (issue) begin
              issue <= (ptr != '0);
            end
          end
        end
        ST_SHIFT: begin
          sh_vld       <= sp_more;
          result_valid <= !sh_vld && !sp_more;
        end
        default: begin
          issue        <= 1'b0;
          chk_vld      <= 1'b0;
          sh_vld       <= 1'b0;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start && req.req_type == REQ_CLICK) begin
          px     <= CB'(req.point_x);
          py     <= CB'(req.point_y);
          n_r    <= n_act;
          ptr    <= AW'(n_act - CW'(1));
          result <= '0;
        end
      end
      ST_SCAN: begin
        chk_pos <= ptr;
        if (issue) begin
          ptr <= ptr - AW'(1);
        end
        if (chk_vld) begin
          if (in_rect) begin
            picked <= rd_data;
            sp     <= CW'(chk_pos) + CW'(1);
          end else if (chk_pos == '0) begin
            result <= '0;
          end
        end
      end
      ST_SHIFT: begin
        if (sp_more) begin
          sp     <= sp + CW'(1);
          sh_pos <= sp;
        end
        if (!sh_vld && !sp_more) begin
          result.hit       <= 1'b1;
          result.window_id <= picked[ENTRY_W-1 -: WIN_ID_W];
        end
      end
      default: ;
    endcase
  end

  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_IDLE)
    else $error("result strobe while a click is still in progress");

  a_miss_zero_id: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |-> result.window_id == '0)
    else $error("miss carries a nonzero window number");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !ram_we)
    else $error("stack written during the scan");

  a_scan_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chk_vld && in_rect) |=> state == ST_SHIFT)
    else $error("hit did not start the rotation");

endmodule

`default_nettype wire
